@@ rtl/core/relay_coil_pulser_with_switch_log_unit_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef RELAY_COIL_PULSER_WITH_SWITCH_LOG_UNIT_MACROS_SVH
`define RELAY_COIL_PULSER_WITH_SWITCH_LOG_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Antecedent and consequent in the same cycle.
`define RCPSL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcpsl assertion failed");
// Consequent in the cycle after the antecedent.
`define RCPSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcpsl assertion failed");
`else
`define RCPSL_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define RCPSL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/rcpsl_pkg.sv @@
package rcpsl_pkg;

    localparam int unsigned RCPSL_PAGE_BYTES = 512;

    localparam int unsigned LIMIT_W  = 32;
    localparam int unsigned PULSE_W  = 8;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned OFFSET_W = 9;
    localparam int unsigned CFG_W    = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RST = 32'd100000;
    localparam logic [PULSE_W-1:0] PULSE_RST = 8'd30;

    typedef enum logic {
        CFG_SWITCH_LIMIT = 1'b0,
        CFG_PULSE_TICKS  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic                coil_no_on;
        logic                coil_nc_on;
        logic [COUNT_W-1:0]  switch_count;
        logic                store_valid;
        logic                erase_page;
        logic [OFFSET_W-1:0] store_offset;
        logic                blocked;
    } t_result;

endpackage

@@ rtl/core/rcpsl_in_if.sv @@
interface rcpsl_in_if
    import rcpsl_pkg::*;
();
    logic valid;
    logic ready;
    logic cmd;
    logic turn_on;

    modport source (output valid, output cmd, output turn_on, input ready);
    modport sink   (input valid, input cmd, input turn_on, output ready);
endinterface

@@ rtl/core/rcpsl_out_if.sv @@
interface rcpsl_out_if
    import rcpsl_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                coil_no_on;
    logic                coil_nc_on;
    logic [COUNT_W-1:0]  switch_count;
    logic                store_valid;
    logic                erase_page;
    logic [OFFSET_W-1:0] store_offset;
    logic                blocked;

    modport source (
        output valid, output coil_no_on, output coil_nc_on, output switch_count,
        output store_valid, output erase_page, output store_offset, output blocked,
        input ready
    );
    modport sink (
        input valid, input coil_no_on, input coil_nc_on, input switch_count,
        input store_valid, input erase_page, input store_offset, input blocked,
        output ready
    );
endinterface

@@ rtl/core/rcpsl_core.sv @@
module rcpsl_core
    import rcpsl_pkg::*;
#(
    parameter int unsigned PAGE_BYTES = RCPSL_PAGE_BYTES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_accept,
    input  logic             i_cmd,
    input  logic             i_turn_on,
    output t_result          o_result
);

    localparam int unsigned OFF_W = $clog2(PAGE_BYTES);

    logic [LIMIT_W-1:0] r_limit;
    logic [PULSE_W-1:0] r_pulse_ticks;

    logic               r_last_req, n_last_req;
    logic [PULSE_W-1:0] r_pulse, n_pulse;
    logic [COUNT_W-1:0] r_total, n_total;
    logic [OFF_W-1:0]   r_slot, n_slot;
    logic               r_no, n_no;
    logic               r_nc, n_nc;

    logic [OFF_W:0]     w_slot_inc;
    logic [OFF_W-1:0]   w_slot_adv;
    logic [OFF_W+8:0]   w_off_ext;
    logic               w_store;
    logic               w_blocked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit       <= LIMIT_RST;
            r_pulse_ticks <= PULSE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SWITCH_LIMIT: r_limit       <= i_cfg_data[LIMIT_W-1:0];
                CFG_PULSE_TICKS:  r_pulse_ticks <= i_cfg_data[PULSE_W-1:0];
                default:          r_limit       <= r_limit;
            endcase
        end
    end

    // Slot ring: advance by one word, wrap at the page end.
    assign w_slot_inc = {1'b0, r_slot} + (OFF_W+1)'(4);
    assign w_slot_adv = (w_slot_inc >= (OFF_W+1)'(PAGE_BYTES)) ? '0 : w_slot_inc[OFF_W-1:0];
    assign w_off_ext  = {9'd0, r_slot};

    always_comb begin
        n_last_req = r_last_req;
        n_pulse    = r_pulse;
        n_total    = r_total;
        n_no       = r_no;
        n_nc       = r_nc;
        w_store    = 1'b0;
        w_blocked  = 1'b0;
        priority if (i_cmd) begin
            n_total = '0;
            w_store = 1'b1;
        end else if ((r_total > r_limit) && !i_turn_on) begin
            w_blocked = 1'b1;
        end else if (r_last_req != i_turn_on) begin
            n_last_req = i_turn_on;
            n_pulse    = '0;
            n_no       = 1'b0;
            n_nc       = 1'b0;
            n_total    = r_total + COUNT_W'(1);
            w_store    = 1'b1;
        end else if (r_pulse <= r_pulse_ticks) begin
            // first tick after a change is the delay tick
            if (r_pulse != '0) begin
                n_no = !i_turn_on;
                n_nc = i_turn_on;
            end
            n_pulse = r_pulse + PULSE_W'(1);
        end else begin
            n_no = 1'b0;
            n_nc = 1'b0;
        end
        n_slot = w_store ? w_slot_adv : r_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_req <= 1'b0;
            r_pulse    <= '0;
            r_total    <= '0;
            r_slot     <= '0;
            r_no       <= 1'b0;
            r_nc       <= 1'b0;
        end else if (i_accept) begin
            r_last_req <= n_last_req;
            r_pulse    <= n_pulse;
            r_total    <= n_total;
            r_slot     <= n_slot;
            r_no       <= n_no;
            r_nc       <= n_nc;
        end
    end

    always_comb begin
        o_result.coil_no_on   = n_no;
        o_result.coil_nc_on   = n_nc;
        o_result.switch_count = n_total;
        o_result.store_valid  = w_store;
        o_result.erase_page   = w_store && (r_slot == '0);
        o_result.store_offset = w_store ? w_off_ext[OFFSET_W-1:0] : '0;
        o_result.blocked      = w_blocked;
    end

endmodule

@@ rtl/core/rcpsl_skid.sv @@
module rcpsl_skid
    import rcpsl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_ready,
    input  logic    i_out_ready,
    output logic    o_valid,
    output t_result o_data
);

    logic    r_out_v;
    logic    r_skid_v;
    t_result r_out;
    t_result r_skid;
    logic    w_advance;

    assign o_ready   = !r_skid_v;
    assign o_valid   = r_out_v;
    assign o_data    = r_out;
    assign w_advance = i_out_ready || !r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_advance) begin
            r_out_v  <= r_skid_v || i_push;
            r_skid_v <= 1'b0;
        end else if (i_push) begin
            r_skid_v <= 1'b1;
        end
    end

    // Hold a word in the skid slot while the output is stalled.
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= r_skid_v ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

@@ rtl/core/relay_coil_pulser_with_switch_log_unit.sv @@
// Accepted results are registered in the output slot, or the skid slot if stalled.
// One word per cycle while input ready is high; each is a registered state update.
// A two-deep output buffer keeps input ready while one result waits downstream.
// Reset (synchronous, active low): state, count and slot offset clear to zero,
// switch_limit returns to 100000 and pulse_ticks to 30; the output buffer empties.
`include "relay_coil_pulser_with_switch_log_unit_macros.svh"

module relay_coil_pulser_with_switch_log_unit
    import rcpsl_pkg::*;
#(
    parameter int unsigned PAGE_BYTES = RCPSL_PAGE_BYTES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rcpsl_in_if.sink         i_in,
    rcpsl_out_if.source      o_out,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic    w_ready;
    logic    w_accept;
    t_result w_result;
    t_result w_out;

    assign i_in.ready = w_ready;
    assign w_accept   = i_in.valid && w_ready;

    rcpsl_core #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (t_cfg_idx'(i_cfg_idx)),
        .i_cfg_data (i_cfg_data),
        .i_accept   (w_accept),
        .i_cmd      (i_in.cmd),
        .i_turn_on  (i_in.turn_on),
        .o_result   (w_result)
    );

    rcpsl_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_accept),
        .i_data      (w_result),
        .o_ready     (w_ready),
        .i_out_ready (o_out.ready),
        .o_valid     (o_out.valid),
        .o_data      (w_out)
    );

    assign o_out.coil_no_on   = w_out.coil_no_on;
    assign o_out.coil_nc_on   = w_out.coil_nc_on;
    assign o_out.switch_count = w_out.switch_count;
    assign o_out.store_valid  = w_out.store_valid;
    assign o_out.erase_page   = w_out.erase_page;
    assign o_out.store_offset = w_out.store_offset;
    assign o_out.blocked      = w_out.blocked;

    `RCPSL_ASSERT_SAME(a_stall_has_word, i_clk, i_rst_n, !i_in.ready, o_out.valid)
    `RCPSL_ASSERT_SAME(a_coils_exclusive, i_clk, i_rst_n, o_out.valid,
        !(o_out.coil_no_on && o_out.coil_nc_on))
    `RCPSL_ASSERT_SAME(a_erase_at_zero, i_clk, i_rst_n, o_out.valid && o_out.erase_page,
        o_out.store_valid && (o_out.store_offset == '0))
    `RCPSL_ASSERT_SAME(a_blocked_no_store, i_clk, i_rst_n, o_out.valid && o_out.blocked,
        !o_out.store_valid)
    `RCPSL_ASSERT_NEXT(a_stall_fills, i_clk, i_rst_n,
        o_out.valid && !o_out.ready && w_accept, !i_in.ready)

endmodule
